// ===== hw/rtl/lpc_to_reflection_with_rms_core_assert.svh =====
// Assertion macros for the LPC to reflection core
`ifndef LPC_TO_REFLECTION_WITH_RMS_CORE_ASSERT_SVH
`define LPC_TO_REFLECTION_WITH_RMS_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LRR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lrr assertion failed");
`define LRR_ASSERT_OUT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lrr output assertion failed");
`else
`define LRR_ASSERT(lbl, prop)
`define LRR_ASSERT_OUT(lbl, prop)
`endif
`endif

// ===== hw/rtl/lrr_pkg.sv =====
// Shared constants, types and helpers for the LPC to reflection core
`timescale 1ns / 1ps
`default_nettype none
package lrr_pkg;
  localparam int COEF_W    = 16;
  localparam int REFL_W    = 13;
  localparam int POS_W     = 4;
  localparam int GAIN_W    = 11;
  localparam int DIV_NUM_W = 25;
  localparam logic [DIV_NUM_W-1:0] DIV_NUM = 25'h1000000;
  localparam logic [31:0] ONE_Q12    = 32'h0000_1000;
  localparam logic [31:0] RANGE_SPAN = 32'h0000_1fff;
  localparam logic [31:0] ONE_Q24    = 32'h0100_0000;
  localparam logic [31:0] GAIN_INIT  = 32'h0001_0000;
  localparam logic [31:0] NORM_LIMIT = 32'h0000_3fff;
  localparam logic [31:0] ROOT_LIMIT = 32'h0000_0fff;
  localparam logic [31:0] ZERO_DEN   = 32'hffff_fffe;

  typedef struct packed {
    logic busy;
    logic done;
  } lrr_unit_st_t;

  function automatic logic [31:0] asr12(input logic [31:0] v);
    return {{12{v[31]}}, v[31:12]};
  endfunction

  function automatic logic out_of_range(input logic [31:0] v);
    return (v + ONE_Q12) > RANGE_SPAN;
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/lrr_if.sv =====
// Valid/ready channel interfaces for coefficients and reflection results
`timescale 1ns / 1ps
`default_nettype none
interface lrr_in_if;
  import lrr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] coefficient;
  logic                     last;
  modport source (output valid, coefficient, last, input ready);
  modport sink (input valid, coefficient, last, output ready);
endinterface

interface lrr_out_if;
  import lrr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [REFL_W-1:0] reflection;
  logic [POS_W-1:0]         position;
  logic                     unstable;
  logic [GAIN_W-1:0]        gain_rms;
  logic                     final_res;
  modport source (output valid, reflection, position, unstable, gain_rms, final_res,
                  input ready);
  modport sink (input valid, reflection, position, unstable, gain_rms, final_res,
                output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lpc_to_reflection_with_rms_core.sv =====
// Coefficients are accepted while idle; the last item starts a run that holds ready low.
// Run: per stage i (ORDER-2 down to 0) a restoring divide (25 steps and a done pulse), then
// S_RD, S_M1, S_M2 and S_WR for each of the i+1 coefficients on the shared multiplier;
// then gain runs S_GRD to S_GN per coefficient, up to 3 scale steps and a square root.
// Results leave one at a time through S_ERD and S_EOUT and wait while the output stalls.
// Reset (async, active low) clears the sequencer, load count and output valid.
`timescale 1ns / 1ps
`default_nettype none
`include "lpc_to_reflection_with_rms_core_assert.svh"
module lpc_to_reflection_with_rms_core #(
  parameter int ORDER = 10
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lrr_in_if.sink    in_ch,
  lrr_out_if.source out_ch
);
  import lrr_pkg::*;

  localparam int IW = $clog2(ORDER);
  localparam int AW = IW + 2;
  localparam logic [1:0] BANK_LOAD = 2'd2;
  localparam logic [IW-1:0] LAST_IDX = IW'(ORDER - 1);

  localparam logic [4:0] S_IDLE = 5'd0,  S_KK  = 5'd1,  S_DEN = 5'd2,  S_DIV = 5'd3,
                         S_RD   = 5'd4,  S_M1  = 5'd5,  S_M2  = 5'd6,  S_WR  = 5'd7,
                         S_GI   = 5'd8,  S_GRD = 5'd9,  S_GKK = 5'd10, S_GF  = 5'd11,
                         S_GP   = 5'd12, S_GN  = 5'd13, S_RSC = 5'd14, S_RSQ = 5'd15,
                         S_ERD  = 5'd16, S_EOUT = 5'd17, S_UOUT = 5'd18;

  logic [4:0]    state_q, state_d;
  logic [IW-1:0] load_q, load_d, i_q, i_d, j_q, j_d, idx_q, idx_d;
  logic [1:0]    src_q, src_d, dst_q, dst_d;
  logic [31:0]   k_q, k_d, q_q, q_d, prod_q, gp_q, gp_d, gain_full;
  logic [8:0]    st_q, st_d;
  logic [4:0]    s_q, s_d;
  logic          neg_q, neg_d;
  logic [GAIN_W-1:0] gain_q, gain_d;

  // scratch and load banks
  logic [31:0]   wa_mem [4 << IW];
  logic          wa_we;
  logic [AW-1:0] wa_waddr, wa_ra0, wa_ra1;
  logic [31:0]   wa_wdata, rd0_q, rd1_q;

  logic [REFL_W-1:0] rf_mem [ORDER];
  logic              rf_we;
  logic [IW-1:0]     rf_waddr;
  logic [REFL_W-1:0] rf_wdata, rr_q;

  logic [31:0] mul_a, mul_b, coef_ext, den, dmag, diff, tval, ks, fval;
  logic [63:0] mul_full;

  logic                 div_start, sq_start;
  logic [DIV_NUM_W-1:0] div_quo;
  logic [15:0]          root;
  lrr_unit_st_t         div_st, sq_st;

  logic in_fire, out_load, out_valid_q;
  logic signed [REFL_W-1:0] o_refl_q, o_refl_d;
  logic [POS_W-1:0]  o_pos_q, o_pos_d;
  logic              o_unst_q, o_unst_d, o_fin_q, o_fin_d;
  logic [GAIN_W-1:0] o_gain_q, o_gain_d;

  lrr_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .divisor_i(dmag),
    .quotient_o(div_quo), .status_o(div_st)
  );

  lrr_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .radicand_i({gp_q[11:0], 20'b0}),
    .root_o(root), .status_o(sq_st)
  );

  assign in_ch.ready = (state_q == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign coef_ext    = {{(32-COEF_W){in_ch.coefficient[COEF_W-1]}}, in_ch.coefficient};

  assign ks   = {{(32-REFL_W){rr_q[REFL_W-1]}}, rr_q};
  assign fval = asr12(ONE_Q24 - prod_q);
  assign diff = rd0_q - asr12(prod_q);
  assign tval = asr12(prod_q);
  assign den  = (ONE_Q12 - asr12(prod_q) == 32'd0) ? ZERO_DEN : ONE_Q12 - asr12(prod_q);
  assign dmag = den[31] ? 32'd0 - den : den;
  assign gain_full = (st_q >= 9'd32) ? 32'd0 :
                     (32'({16'b0, root} << s_q) >> st_q[4:0]);

  // shared multiplier, low word only
  always_comb begin
    case (state_q)
      S_KK:    begin mul_a = k_q;  mul_b = k_q;   end
      S_M1:    begin mul_a = k_q;  mul_b = rd1_q; end
      S_M2:    begin mul_a = diff; mul_b = q_q;   end
      S_GKK:   begin mul_a = ks;   mul_b = ks;    end
      S_GF:    begin mul_a = fval; mul_b = gp_q;  end
      default: begin mul_a = '0;   mul_b = '0;    end
    endcase
  end
  assign mul_full = 64'(mul_a) * 64'(mul_b);

  assign out_load = (state_q == S_EOUT || state_q == S_UOUT) &&
                    (!out_valid_q || out_ch.ready);

  always_comb begin
    state_d = state_q;
    load_d = load_q;  i_d = i_q;  j_d = j_q;  idx_d = idx_q;
    src_d = src_q;  dst_d = dst_q;  k_d = k_q;  q_d = q_q;  neg_d = neg_q;
    gp_d = gp_q;  st_d = st_q;  s_d = s_q;  gain_d = gain_q;
    wa_we = 1'b0;  wa_waddr = {BANK_LOAD, load_q};  wa_wdata = coef_ext;
    wa_ra0 = {src_q, j_q};  wa_ra1 = {src_q, IW'(i_q - j_q)};
    rf_we = 1'b0;  rf_waddr = LAST_IDX;  rf_wdata = coef_ext[REFL_W-1:0];
    div_start = 1'b0;  sq_start = 1'b0;
    o_refl_d = o_refl_q;  o_pos_d = o_pos_q;  o_unst_d = o_unst_q;
    o_fin_d = o_fin_q;  o_gain_d = o_gain_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (!in_ch.last) begin
            if (load_q < LAST_IDX) begin
              wa_we  = 1'b1;
              load_d = load_q + 1'b1;
            end
          end else begin
            wa_we    = 1'b1;
            wa_waddr = {BANK_LOAD, LAST_IDX};
            load_d   = '0;
            k_d      = coef_ext;
            if (out_of_range(coef_ext)) begin
              state_d = S_UOUT;
            end else begin
              rf_we   = 1'b1;
              i_d     = IW'(ORDER - 2);
              j_d     = '0;
              src_d   = BANK_LOAD;
              dst_d   = 2'd0;
              state_d = S_KK;
            end
          end
        end
      end
      S_KK: state_d = S_DEN;
      S_DEN: begin
        neg_d     = den[31];
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_st.done) begin
          q_d     = neg_q ? 32'd0 - 32'(div_quo) : 32'(div_quo);
          j_d     = '0;
          state_d = S_RD;
        end
      end
      S_RD: state_d = S_M1;
      S_M1: state_d = S_M2;
      S_M2: state_d = S_WR;
      S_WR: begin
        wa_we    = 1'b1;
        wa_waddr = {dst_q, j_q};
        wa_wdata = tval;
        if (j_q == i_q) begin
          if (out_of_range(tval)) begin
            state_d = S_UOUT;
          end else begin
            rf_we    = 1'b1;
            rf_waddr = i_q;
            rf_wdata = tval[REFL_W-1:0];
            k_d      = tval;
            if (i_q == '0) begin
              state_d = S_GI;
            end else begin
              i_d     = i_q - 1'b1;
              src_d   = dst_q;
              dst_d   = (dst_q == 2'd0) ? 2'd1 : 2'd0;
              state_d = S_KK;
            end
          end
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_GI: begin
        gp_d    = GAIN_INIT;
        st_d    = 9'd10;
        idx_d   = '0;
        state_d = S_GRD;
      end
      S_GRD: state_d = S_GKK;
      S_GKK: state_d = S_GF;
      S_GF:  state_d = S_GP;
      S_GP: begin
        gp_d = {12'b0, prod_q[31:12]};
        if (prod_q[31:12] == 20'd0) begin
          gain_d  = '0;
          idx_d   = '0;
          state_d = S_ERD;
        end else begin
          state_d = S_GN;
        end
      end
      S_GN: begin
        if (gp_q <= NORM_LIMIT) begin
          gp_d = gp_q << 2;
          st_d = st_q + 1'b1;
        end else if (idx_q == LAST_IDX) begin
          s_d     = 5'd2;
          state_d = S_RSC;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_GRD;
        end
      end
      S_RSC: begin
        if (gp_q > ROOT_LIMIT) begin
          gp_d = gp_q >> 2;
          s_d  = s_q + 1'b1;
        end else begin
          sq_start = 1'b1;
          state_d  = S_RSQ;
        end
      end
      S_RSQ: begin
        if (sq_st.done) begin
          gain_d  = gain_full[GAIN_W-1:0];
          idx_d   = '0;
          state_d = S_ERD;
        end
      end
      S_ERD: state_d = S_EOUT;
      S_EOUT: begin
        if (out_load) begin
          o_refl_d = rr_q;
          o_pos_d  = POS_W'(idx_q);
          o_unst_d = 1'b0;
          o_fin_d  = (idx_q == LAST_IDX);
          o_gain_d = (idx_q == LAST_IDX) ? gain_q : '0;
          if (idx_q == LAST_IDX) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_ERD;
          end
        end
      end
      S_UOUT: begin
        if (out_load) begin
          o_refl_d = '0;
          o_pos_d  = '0;
          o_unst_d = 1'b1;
          o_fin_d  = 1'b1;
          o_gain_d = '0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wa_we) wa_mem[wa_waddr] <= wa_wdata;
    rd0_q <= wa_mem[wa_ra0];
    rd1_q <= wa_mem[wa_ra1];
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
    rr_q <= rf_mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      load_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      load_q  <= load_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d;  j_q <= j_d;  idx_q <= idx_d;
    src_q <= src_d;  dst_q <= dst_d;
    k_q <= k_d;  q_q <= q_d;  neg_q <= neg_d;
    prod_q <= mul_full[31:0];
    gp_q <= gp_d;  st_q <= st_d;  s_q <= s_d;  gain_q <= gain_d;
    o_refl_q <= o_refl_d;  o_pos_q <= o_pos_d;  o_unst_q <= o_unst_d;
    o_fin_q <= o_fin_d;  o_gain_q <= o_gain_d;
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.reflection = o_refl_q;
  assign out_ch.position   = o_pos_q;
  assign out_ch.unstable   = o_unst_q;
  assign out_ch.gain_rms   = o_gain_q;
  assign out_ch.final_res  = o_fin_q;

  `LRR_ASSERT(a_idle_units, in_ch.ready |-> !div_st.busy && !sq_st.busy)
  `LRR_ASSERT(a_last_blocks, in_fire && in_ch.last |=> !in_ch.ready)
  `LRR_ASSERT_OUT(a_gain_final, out_ch.valid && !out_ch.final_res |-> out_ch.gain_rms == '0)
  `LRR_ASSERT_OUT(a_unstable_single,
    out_ch.valid && out_ch.unstable |-> out_ch.final_res && out_ch.reflection == '0)
endmodule
`default_nettype wire

// ===== hw/rtl/lrr_div.sv =====
// Restoring divider: fixed Q24 numerator over a 32-bit magnitude, one bit a cycle
`timescale 1ns / 1ps
`default_nettype none
module lrr_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [31:0]                    divisor_i,
  output logic [lrr_pkg::DIV_NUM_W-1:0]       quotient_o,
  output lrr_pkg::lrr_unit_st_t               status_o
);
  import lrr_pkg::*;

  localparam int CW = $clog2(DIV_NUM_W);

  logic                 busy_q, busy_d, done_q, done_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [31:0]          rem_q, rem_d, div_q, div_d;
  logic [DIV_NUM_W-1:0] quo_q, quo_d;
  logic [32:0]          shifted;
  logic                 fits;

  assign shifted = {rem_q, quo_q[DIV_NUM_W-1]};
  assign fits    = shifted >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      div_d  = divisor_i;
      quo_d  = DIV_NUM;
    end else if (busy_q) begin
      rem_d = fits ? 32'(shifted - {1'b0, div_q}) : shifted[31:0];
      quo_d = {quo_q[DIV_NUM_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DIV_NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign quotient_o = quo_q;
  assign status_o   = '{busy: busy_q, done: done_q};
endmodule
`default_nettype wire

// ===== hw/rtl/lrr_sqrt.sv =====
// Bit-pair integer square root, floor result, one step a cycle
`timescale 1ns / 1ps
`default_nettype none
module lrr_sqrt (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [31:0]       radicand_i,
  output logic [15:0]            root_o,
  output lrr_pkg::lrr_unit_st_t  status_o
);
  import lrr_pkg::*;

  logic        busy_q, busy_d, done_q, done_d;
  logic [31:0] x_q, x_d, r_q, r_d, bit_q, bit_d, trial;

  assign trial = r_q + bit_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    x_d    = x_q;
    r_d    = r_q;
    bit_d  = bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      x_d    = radicand_i;
      r_d    = '0;
      bit_d  = 32'h4000_0000;
    end else if (busy_q) begin
      if (x_q >= trial) begin
        x_d = x_q - trial;
        r_d = (r_q >> 1) + bit_q;
      end else begin
        r_d = r_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q == 32'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

  assign root_o   = r_q[15:0];
  assign status_o = '{busy: busy_q, done: done_q};
endmodule
`default_nettype wire
